// ===== rtl/core/spectral_noise_floor_trigger_assert.svh =====
// assertion macros for the spectral noise floor trigger checker
// no dependencies; included by the checker file only
`ifndef SPECTRAL_NOISE_FLOOR_TRIGGER_ASSERT_SVH
`define SPECTRAL_NOISE_FLOOR_TRIGGER_ASSERT_SVH

// same-cycle implication, off during reset
`define SNFT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("snft assertion failed");

// next-cycle implication, off during reset
`define SNFT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("snft assertion failed");

`endif

// ===== rtl/core/snft_pkg.sv =====
// shared types and constants of the spectral noise floor trigger
// no dependencies
package snft_pkg;

   localparam int AMP_W      = 16;
   localparam int PF_W       = 18;
   localparam int AREA_W     = 17;
   localparam int HIST_W     = 10;
   localparam int FB_W       = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int GAIN_W     = 9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARMED       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_BIN   = 2'd2;

   localparam logic [HIST_W-1:0] HIST_RESET  = 10'd430;
   localparam logic [FB_W-1:0]   FIRST_RESET = 8'd10;

   // 1.2 in q8 units, 0.2 in q8.8, and area > 1.0 means root > 256 + 51
   localparam logic [GAIN_W-1:0] GAIN_MUL = 9'd307;
   localparam int AREA_BIAS = 51;
   localparam int TRIG_ROOT = 307;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } unit_cmd_type;

endpackage

// ===== rtl/core/snft_channels.sv =====
// request and response channel interfaces
// depends on snft_pkg
interface snft_req_if import snft_pkg::*;;
   logic             valid;
   logic             ready;
   logic [AMP_W-1:0] bin_amplitude;

   modport source (output valid, output bin_amplitude, input ready);
   modport sink   (input valid, input bin_amplitude, output ready);
endinterface

interface snft_rsp_if import snft_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [PF_W-1:0]   post_filter;
   logic [AMP_W-1:0]         noise_floor;
   logic                     frame_end;
   logic signed [AREA_W-1:0] area;
   logic                     trigger;

   modport source (output valid, output post_filter, output noise_floor,
                   output frame_end, output area, output trigger, input ready);
   modport sink   (input valid, input post_filter, input noise_floor,
                   input frame_end, input area, input trigger, output ready);
endinterface

// ===== rtl/core/snft_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
module snft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/snft_divsqrt.sv =====
// shared bit-serial unit: restoring divide or integer square root
// depends on snft_pkg
module snft_divsqrt import snft_pkg::*; #(
   parameter int SUMW = 25,
   parameter int RADW = 32,
   parameter int LENW = 10,
   parameter int QW   = (SUMW > RADW / 2) ? SUMW : RADW / 2
) (
   input  logic            clock,
   input  logic            reset,
   input  unit_cmd_type    cmd,
   input  logic [SUMW-1:0] div_value,
   input  logic [LENW-1:0] divisor,
   input  logic [RADW-1:0] sqrt_value,
   output logic            done,
   output logic [QW-1:0]   result
);

   localparam int ROOTW = RADW / 2;
   localparam int SW    = (SUMW > RADW) ? SUMW : RADW;
   localparam int RW    = (LENW + 1 > ROOTW + 3) ? LENW + 1 : ROOTW + 3;
   localparam int STMAX = (SUMW > ROOTW) ? SUMW : ROOTW;
   localparam int CNTW  = $clog2(STMAX + 1);

   logic [SW-1:0]   src_ff, src_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [LENW-1:0] div_ff, div_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            sqrt_ff, sqrt_in;
   logic            done_ff, done_in;

   logic [RW-1:0] shifted;
   logic [RW-1:0] trial;
   logic          ge;

   always_comb begin
      if (sqrt_ff) begin
         shifted = {rem_ff[RW-3:0], src_ff[SW-1 -: 2]};
         trial   = RW'({q_ff[ROOTW-1:0], 2'b01});
      end else begin
         shifted = {rem_ff[RW-2:0], src_ff[SW-1]};
         trial   = RW'(div_ff);
      end
      ge = (shifted >= trial);
   end

   always_comb begin
      src_in  = src_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         sqrt_in = cmd.is_sqrt;
         div_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         busy_in = 1'b1;
         if (cmd.is_sqrt) begin
            src_in = SW'(sqrt_value) << (SW - RADW);
            cnt_in = CNTW'(ROOTW);
         end else begin
            src_in = SW'(div_value) << (SW - SUMW);
            cnt_in = CNTW'(SUMW);
         end
      end else if (busy_ff) begin
         rem_in = ge ? (shifted - trial) : shifted;
         q_in   = {q_ff[QW-2:0], ge};
         src_in = sqrt_ff ? (src_ff << 2) : (src_ff << 1);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         sqrt_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         sqrt_ff <= sqrt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   assign done   = done_ff;
   assign result = q_ff;

endmodule

// ===== rtl/core/spectral_noise_floor_trigger.sv =====
// top level of the spectral noise floor trigger
// depends on snft_pkg, snft_channels, snft_ram and snft_divsqrt
// per request: ring and sum read, divide by the history length, gain multiply, square root
//   on the last bin of a frame only, then the registered response
// one request in flight: none is taken until the last one's response is registered; the
//   bit-serial divide/root unit sets the pace, and a stalled response holds the next one
// reset (synchronous, active high) starts a pass that zeroes the spectrum ring and
//   the bin sums entry by entry, and takes no request while it runs;
//   the same pass runs after a trigger and after a history_len write
module spectral_noise_floor_trigger import snft_pkg::*; #(
   parameter int BINS          = 256,
   parameter int HISTORY_DEPTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   snft_req_if.sink              req_ch,
   snft_rsp_if.source            rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int BW         = $clog2(BINS);
   localparam int LENW       = $clog2(HISTORY_DEPTH + 1);
   localparam int SUMW       = AMP_W + $clog2(HISTORY_DEPTH);
   localparam int ACCW       = AMP_W + BW;
   localparam int RADW       = ACCW + 8 + (ACCW % 2);
   localparam int ROOTW      = RADW / 2;
   localparam int QW         = (SUMW > ROOTW) ? SUMW : ROOTW;
   localparam int RING_DEPTH = HISTORY_DEPTH * BINS;
   localparam int ADDRW      = $clog2(RING_DEPTH);
   localparam int CW         = (BW > FB_W) ? BW : FB_W;
   localparam int CMPW       = (LENW > HIST_W) ? LENW : HIST_W;
   localparam int PRODW      = AMP_W + GAIN_W;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_SQRT = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [HIST_W-1:0] hist_ff, hist_in;
   logic              armed_ff, armed_in;
   logic [FB_W-1:0]   first_ff, first_in;
   logic [BW-1:0]     pos_ff, pos_in;
   logic [LENW-1:0]   slot_ff, slot_in;
   logic [ADDRW-1:0]  row_ff, row_in;
   logic [ACCW-1:0]   acc_ff, acc_in;
   logic              clr_ff, clr_in;
   logic [ADDRW-1:0]  clr_addr_ff, clr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers, no reset
   logic [AMP_W-1:0]         amp_ff, amp_in;
   logic [AMP_W-1:0]         noise_ff, noise_in;
   logic [PRODW-1:0]         prod_ff, prod_in;
   logic [ROOTW-1:0]         root_ff, root_in;
   logic signed [PF_W-1:0]   pf_ff, pf_in;
   logic [AMP_W-1:0]         nf_ff, nf_in;
   logic                     fe_ff, fe_in;
   logic signed [AREA_W-1:0] area_ff, area_in;
   logic                     trig_ff, trig_in;

   logic                   accept;
   logic                   last;
   logic [LENW-1:0]        len;
   logic [CMPW-1:0]        hist_x;
   logic [ADDRW-1:0]       ring_addr;
   logic [AMP_W-1:0]       ring_rd;
   logic [SUMW-1:0]        sum_rd;
   logic [SUMW-1:0]        new_sum;
   logic [ACCW-1:0]        acc_sum;
   logic                   counted;
   logic                   slot_wrap;
   logic signed [ROOTW:0]  area_full;
   logic                   fire;
   logic                   ring_we, sum_we;
   logic [ADDRW-1:0]       ring_wa;
   logic [AMP_W-1:0]       ring_wd;
   logic [BW-1:0]          sum_wa;
   logic [SUMW-1:0]        sum_wd;
   logic                   clr_in_bins;
   unit_cmd_type           cmd;
   logic                   unit_done;
   logic [QW-1:0]          unit_q;

   assign accept = req_ch.valid && req_ch.ready;
   // one request in flight, and none during the clearing pass
   assign req_ch.ready = (state_ff == S_IDLE) && !clr_ff;
   assign last = (pos_ff == BW'(BINS - 1));

   // effective history length: zero means one, clamp at HISTORY_DEPTH
   always_comb begin
      hist_x = CMPW'(hist_ff);
      if (hist_x == '0) begin
         len = LENW'(1);
      end else if (hist_x > CMPW'(HISTORY_DEPTH)) begin
         len = LENW'(HISTORY_DEPTH);
      end else begin
         len = LENW'(hist_x);
      end
   end

   // ring slot rows are kept as a base address, so no multiply per bin
   assign ring_addr = row_ff + ADDRW'(pos_ff);
   // sum update: the old ring entry leaves, the new amplitude enters
   assign new_sum   = sum_rd - SUMW'(ring_rd) + SUMW'(amp_ff);
   assign counted   = (CW'(pos_ff) >= CW'(first_ff));
   assign acc_sum   = acc_ff + (counted ? ACCW'(noise_ff) : '0);
   assign slot_wrap = ((slot_ff + 1'b1) == len);

   // area = root - 0.2, trigger needs area above 1.0
   assign area_full = $signed({1'b0, root_ff}) - (ROOTW + 1)'(AREA_BIAS);
   assign fire = last && armed_ff && (root_ff > ROOTW'(TRIG_ROOT));

   // memory write muxes: the clearing pass owns both write ports
   assign clr_in_bins = ({1'b0, clr_addr_ff} < (ADDRW + 1)'(BINS));
   always_comb begin
      if (clr_ff) begin
         ring_we = 1'b1;
         ring_wa = clr_addr_ff;
         ring_wd = '0;
         sum_we  = clr_in_bins;
         sum_wa  = clr_addr_ff[BW-1:0];
         sum_wd  = '0;
      end else begin
         ring_we = (state_ff == S_READ);
         ring_wa = ring_addr;
         ring_wd = amp_ff;
         sum_we  = (state_ff == S_READ);
         sum_wa  = pos_ff;
         sum_wd  = new_sum;
      end
   end

   snft_ram #(
      .WIDTH (AMP_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (ring_wd),
      .rd_en   (accept),
      .rd_addr (ring_addr),
      .rd_data (ring_rd)
   );

   snft_ram #(
      .WIDTH (SUMW),
      .DEPTH (BINS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_wa),
      .wr_data (sum_wd),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (sum_rd)
   );

   // divide on every bin, square root only on the last bin of a frame
   assign cmd.start   = (state_ff == S_READ) || ((state_ff == S_MUL) && last);
   assign cmd.is_sqrt = (state_ff == S_MUL);

   snft_divsqrt #(
      .SUMW (SUMW),
      .RADW (RADW),
      .LENW (LENW),
      .QW   (QW)
   ) u_unit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .div_value  (new_sum),
      .divisor    (len),
      .sqrt_value (RADW'({acc_sum, 8'b0})),
      .done       (unit_done),
      .result     (unit_q)
   );

   always_comb begin
      state_in     = state_ff;
      hist_in      = hist_ff;
      armed_in     = armed_ff;
      first_in     = first_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      row_in       = row_ff;
      acc_in       = acc_ff;
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      amp_in       = amp_ff;
      noise_in     = noise_ff;
      prod_in      = prod_ff;
      root_in      = root_ff;
      pf_in        = pf_ff;
      nf_in        = nf_ff;
      fe_in        = fe_ff;
      area_in      = area_ff;
      trig_in      = trig_ff;

      // clearing pass, one ring entry a cycle
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDRW'(RING_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               amp_in   = req_ch.bin_amplitude;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (unit_done) begin
               noise_in = unit_q[AMP_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = noise_ff * GAIN_MUL;
            acc_in   = acc_sum;
            state_in = last ? S_SQRT : S_DONE;
         end
         S_SQRT: begin
            if (unit_done) begin
               root_in  = unit_q[ROOTW-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               pf_in   = PF_W'({2'b00, amp_ff}) - PF_W'(prod_ff[PRODW-1:8]);
               nf_in   = noise_ff;
               fe_in   = last;
               area_in = last ? AREA_W'(area_full) : '0;
               trig_in = fire;
               if (last) begin
                  pos_in = '0;
                  acc_in = '0;
                  slot_in = slot_wrap ? '0 : (slot_ff + 1'b1);
                  row_in  = slot_wrap ? '0 : (row_ff + ADDRW'(BINS));
                  if (fire) begin
                     clr_in      = 1'b1;
                     clr_addr_in = '0;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes, to be made only while idle; the block itself does not enforce it
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HISTORY_LEN: begin
               hist_in     = csr_write_data[HIST_W-1:0];
               slot_in     = '0;
               row_in      = '0;
               clr_in      = 1'b1;
               clr_addr_in = '0;
            end
            CSR_ARMED: begin
               armed_in = csr_write_data[0];
            end
            CSR_FIRST_BIN: begin
               first_in = csr_write_data[FB_W-1:0];
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hist_ff      <= HIST_RESET;
         armed_ff     <= 1'b0;
         first_ff     <= FIRST_RESET;
         pos_ff       <= '0;
         slot_ff      <= '0;
         row_ff       <= '0;
         acc_ff       <= '0;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         armed_ff     <= armed_in;
         first_ff     <= first_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         row_ff       <= row_in;
         acc_ff       <= acc_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amp_ff   <= amp_in;
      noise_ff <= noise_in;
      prod_ff  <= prod_in;
      root_ff  <= root_in;
      pf_ff    <= pf_in;
      nf_ff    <= nf_in;
      fe_ff    <= fe_in;
      area_ff  <= area_in;
      trig_ff  <= trig_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.post_filter = pf_ff;
   assign rsp_ch.noise_floor = nf_ff;
   assign rsp_ch.frame_end   = fe_ff;
   assign rsp_ch.area        = area_ff;
   assign rsp_ch.trigger     = trig_ff;

endmodule

// ===== rtl/core/snft_checker.sv =====
// port-level checker for the spectral noise floor trigger, bound to the top level
// depends on snft_pkg and spectral_noise_floor_trigger_assert.svh
`include "spectral_noise_floor_trigger_assert.svh"

module snft_checker import snft_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              frame_end,
   input logic [AREA_W-1:0] area,
   input logic              trigger
);

   `SNFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SNFT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `SNFT_ASSERT_NOW(a_area_mid_frame, clock, reset, rsp_valid && !frame_end, area == '0 && !trigger)
   `SNFT_ASSERT_NOW(a_trig_area, clock, reset, rsp_valid && trigger, $signed(area) > 17'sd256)

endmodule

bind spectral_noise_floor_trigger snft_checker u_snft_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .frame_end (rsp_ch.frame_end),
   .area      (rsp_ch.area),
   .trigger   (rsp_ch.trigger)
);

// ===== bench/tb_spectral_noise_floor_trigger.sv =====
`timescale 1ns / 100ps
// self-checking bench for spectral_noise_floor_trigger: per-bin noise floor,
// post-filter, frame area and trigger checked against an in-bench predictor
// depends on snft_pkg, snft_channels and the rtl of the block
module tb_spectral_noise_floor_trigger;
   import snft_pkg::*;

   localparam int BINS       = 256;
   localparam int HIST_DEPTH = 512;

   typedef struct packed {
      logic signed [PF_W-1:0]   post_filter;
      logic [AMP_W-1:0]         noise_floor;
      logic                     frame_end;
      logic signed [AREA_W-1:0] area;
      logic                     trigger;
   } bin_result_type;

   // amplitude mixes for the random part
   typedef enum int {AMP_FULL, AMP_TINY, AMP_MIXED} amp_mix_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   snft_req_if req_ch ();
   snft_rsp_if rsp_ch ();

   spectral_noise_floor_trigger #(.BINS(BINS), .HISTORY_DEPTH(HIST_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state, a copy of the block's history
   logic [AMP_W-1:0] hist_ring [0:HIST_DEPTH*BINS-1];
   int unsigned      bin_sum [0:BINS-1];
   int unsigned      ring_slot;
   int unsigned      bin_pos;
   longint unsigned  floor_acc;
   int unsigned      hist_len_reg;
   bit               armed_reg;
   int unsigned      first_bin_reg;
   int unsigned      trigger_count;

   logic [AMP_W-1:0] pending_amps [$];
   bin_result_type   expected_bins [$];
   int unsigned      mismatches;
   bit               stim_done;

   // clock and the single reset
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic void clear_history();
      for (int i = 0; i < HIST_DEPTH*BINS; i++) hist_ring[i] = '0;
      for (int i = 0; i < BINS; i++) bin_sum[i] = 0;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // advance the predicted state by one bin and return its result
   function automatic bin_result_type predict_bin(logic [AMP_W-1:0] amp);
      bin_result_type r;
      int unsigned len;
      int unsigned slot;
      int unsigned idx;
      int unsigned noise;
      longint signed post;
      longint signed area_v;
      len = (hist_len_reg == 0) ? 1 :
            (hist_len_reg > HIST_DEPTH) ? HIST_DEPTH : hist_len_reg;
      slot = ring_slot % len;
      idx = slot * BINS + bin_pos;
      bin_sum[bin_pos] = bin_sum[bin_pos] - hist_ring[idx] + amp;
      hist_ring[idx] = amp;
      noise = (bin_sum[bin_pos] / len) & 16'hFFFF;
      post = longint'(amp) - longint'((noise * 307) >> 8);
      if (bin_pos >= first_bin_reg) floor_acc += noise;
      r = '0;
      r.post_filter = post[PF_W-1:0];
      r.noise_floor = noise[AMP_W-1:0];
      if (bin_pos == BINS-1) begin
         area_v = longint'(root_floor(floor_acc << 8)) - 51;
         r.frame_end = 1'b1;
         r.area = area_v[AREA_W-1:0];
         ring_slot = (slot + 1) % len;
         if (armed_reg && area_v > 256) begin
            r.trigger = 1'b1;
            trigger_count++;
            clear_history();
         end
         floor_acc = 0;
         bin_pos = 0;
      end else begin
         bin_pos = bin_pos + 1;
      end
      return r;
   endfunction

   task automatic send_bin(logic [AMP_W-1:0] amp);
      pending_amps.push_back(amp);
      expected_bins.push_back(predict_bin(amp));
   endtask

   function automatic logic [AMP_W-1:0] pick_amp(amp_mix_type mix);
      case (mix)
         AMP_TINY: return $urandom_range(0, 3);
         AMP_MIXED: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return 16'hFFFF;
               2: return $urandom_range(0, 255);
               default: return $urandom_range(0, 65535);
            endcase
         end
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic send_random(int n, amp_mix_type mix);
      repeat (n) send_bin(pick_amp(mix));
   endtask

   // all requests answered, then let any tail of work drain
   task automatic wait_idle();
      wait (pending_amps.size() == 0 && expected_bins.size() == 0);
      repeat (64) @(posedge clock);
   endtask

   // register write, mirrored into the predictor
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_en   <= 1'b0;
      case (idx)
         CSR_HISTORY_LEN: begin
            hist_len_reg = value & 10'h3FF;
            clear_history();
            ring_slot = 0;
         end
         CSR_ARMED:     armed_reg = value[0];
         CSR_FIRST_BIN: first_bin_reg = value & 8'hFF;
         default: ;
      endcase
   endtask

   // stimulus
   initial begin
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_write_data = '0;
      stim_done      = 1'b0;
      clear_history();
      ring_slot = 0;
      bin_pos = 0;
      floor_acc = 0;
      hist_len_reg = HIST_RESET;
      armed_reg = 1'b0;
      first_bin_reg = FIRST_RESET;
      trigger_count = 0;
      wait (reset == 1'b0);

      // directed: field extremes and patterns at reset settings
      send_bin(16'h0000); send_bin(16'hFFFF); send_bin(16'h0001); send_bin(16'hFFFE);
      send_bin(16'h8000); send_bin(16'h7FFF); send_bin(16'h00FF); send_bin(16'hFF00);
      send_bin(16'h5555); send_bin(16'hAAAA);
      repeat (4) send_bin(16'hFFFF);
      repeat (2) send_bin(16'h0000);
      send_random(80, AMP_MIXED);
      wait_idle();

      // zero length is taken as one, all bins counted
      write_reg(CSR_HISTORY_LEN, 0);
      write_reg(CSR_FIRST_BIN, 0);
      send_random(90, AMP_FULL);
      wait_idle();

      // oversize length is taken as the full depth, only the top bin counted
      write_reg(CSR_HISTORY_LEN, 1023);
      write_reg(CSR_FIRST_BIN, 255);
      send_random(70, AMP_MIXED);
      wait_idle();

      // armed with quiet frames, then a loud frame that fires
      write_reg(CSR_HISTORY_LEN, 3);
      write_reg(CSR_FIRST_BIN, 200);
      write_reg(CSR_ARMED, 1);
      while (bin_pos != 0) send_bin(pick_amp(AMP_TINY));
      send_random(BINS, AMP_TINY);
      wait_idle();
      write_reg(CSR_FIRST_BIN, 0);
      begin
         int unsigned fired;
         fired = trigger_count;
         while (trigger_count == fired) send_bin(pick_amp(AMP_FULL));
      end
      wait_idle();

      // disarmed again, history starts from a cleared ring
      write_reg(CSR_ARMED, 0);
      write_reg(CSR_FIRST_BIN, 128);
      send_random(180, AMP_MIXED);
      stim_done = 1'b1;
   end

   // request driver: per-item gap, with stretches of back-to-back traffic
   int unsigned req_gap;
   bit          req_burst;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.bin_amplitude = '0;
      req_gap = 0;
      req_burst = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_amps.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.bin_amplitude <= pending_amps.pop_front();
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
            req_gap <= req_burst ? 0 : $urandom_range(0, 19);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response monitor and checker, with random back-pressure
   int unsigned rsp_stall;
   bit          rsp_burst;

   initial begin
      rsp_ch.ready = 1'b0;
      rsp_stall = 0;
      rsp_burst = 1'b0;
      mismatches = 0;
   end

   always @(posedge clock) begin
      bin_result_type want;
      bin_result_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         got.post_filter = rsp_ch.post_filter;
         got.noise_floor = rsp_ch.noise_floor;
         got.frame_end   = rsp_ch.frame_end;
         got.area        = rsp_ch.area;
         got.trigger     = rsp_ch.trigger;
         if (expected_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: pf=%0d nf=%0d fe=%0b area=%0d trig=%0b",
                        got.post_filter, got.noise_floor, got.frame_end,
                        got.area, got.trigger);
         end else begin
            want = expected_bins.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp pf=%0d nf=%0d fe=%0b area=%0d trig=%0b",
                           want.post_filter, want.noise_floor, want.frame_end,
                           want.area, want.trigger);
                  $display("          got pf=%0d nf=%0d fe=%0b area=%0d trig=%0b",
                           got.post_filter, got.noise_floor, got.frame_end,
                           got.area, got.trigger);
               end
            end
         end
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         rsp_stall <= rsp_burst ? 0 : $urandom_range(0, 19);
         rsp_ch.ready <= rsp_burst;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ch.ready <= (rsp_stall == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // end of run: drain, settle, then report
   initial begin
      wait (stim_done);
      wait (pending_amps.size() == 0 && expected_bins.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_bins.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
